// ===== sv/pmd_pkg.sv =====
// ----------------------------------------------------------------------------
// pmd_pkg
// Shared types and constants of the pushbuffer method decoder.
// ----------------------------------------------------------------------------
package pmd_pkg;

    // Header field widths
    localparam int unsigned WORD_W   = 32;
    localparam int unsigned METHOD_W = 14;
    localparam int unsigned COUNT_W  = 13;
    localparam int unsigned SUBCH_W  = 3;
    localparam int unsigned CLASS_W  = 2;
    localparam int unsigned HOST_W   = 13;

    // Decoupling queue between decode and issue
    localparam int unsigned QDEPTH   = 4;
    localparam int unsigned QPTR_W   = $clog2(QDEPTH);
    localparam int unsigned QCNT_W   = $clog2(QDEPTH + 1);

    // Secondary opcodes (header bits 31:29)
    localparam logic [2:0] OP_GRP0_USE_TERT = 3'd0;
    localparam logic [2:0] OP_INC           = 3'd1;
    localparam logic [2:0] OP_NONINC        = 3'd3;
    localparam logic [2:0] OP_IMMD          = 3'd4;
    localparam logic [2:0] OP_ONEINC        = 3'd5;
    localparam logic [2:0] OP_END_SEG       = 3'd7;

    // Tertiary opcode (header bits 18:16) under group 0
    localparam logic [2:0] TERT_SET_SUBDEV_MASK = 3'd1;

    // Configuration register indexes
    localparam logic CFG_HOST_LIMIT   = 1'b0;
    localparam logic CFG_ENGINE_LIMIT = 1'b1;

    localparam logic [HOST_W-1:0]   HOST_LIMIT_RST   = 13'd64;
    localparam logic [METHOD_W-1:0] ENGINE_LIMIT_RST = 14'd3584;

    // Target classes
    localparam logic [CLASS_W-1:0] CLASS_HOST   = 2'd0;
    localparam logic [CLASS_W-1:0] CLASS_ENGINE = 2'd1;
    localparam logic [CLASS_W-1:0] CLASS_MACRO  = 2'd2;

    // Result status
    localparam logic STATUS_WRITE = 1'b0;
    localparam logic STATUS_ERROR = 1'b1;

    typedef enum logic [1:0] {
        MODE_HEADER = 2'd0,
        MODE_INC    = 2'd1,
        MODE_NONINC = 2'd2,
        MODE_ONEINC = 2'd3
    } t_mode;

    // One decoded result word travelling from decode to issue
    typedef struct packed {
        logic                status;
        logic [METHOD_W-1:0] method;
        logic [WORD_W-1:0]   argument;
        logic [SUBCH_W-1:0]  subchannel;
        logic                last;
    } t_cmd;

    // Queue status seen by its producer and consumer
    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

endpackage

// ===== sv/pmd_front.sv =====
// ----------------------------------------------------------------------------
// pmd_front
// Header decode and method sequencing; emits at most one command per word.
// ----------------------------------------------------------------------------
module pmd_front
    import pmd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [WORD_W-1:0] i_word,
    input  logic              i_entry_start,
    output logic              o_cmd_valid,
    output t_cmd              o_cmd
);

    t_mode               r_mode,  n_mode;
    logic [COUNT_W-1:0]  r_rem,   n_rem;
    logic [METHOD_W-1:0] r_meth,  n_meth;
    logic [SUBCH_W-1:0]  r_sub,   n_sub;
    logic                r_skip,  n_skip;

    logic               skip_now;
    logic [COUNT_W-1:0] rem_dec;
    logic [2:0]         sec;
    logic [2:0]         tert;
    logic [COUNT_W-1:0] hdr_cnt;
    logic [11:0]        hdr_addr;
    logic [SUBCH_W-1:0] hdr_sub;

    assign sec      = i_word[31:29];
    assign tert     = i_word[18:16];
    assign hdr_cnt  = i_word[28:16];
    assign hdr_addr = i_word[11:0];
    assign hdr_sub  = i_word[15:13];
    assign skip_now = i_entry_start ? 1'b0 : r_skip;
    assign rem_dec  = r_rem - COUNT_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_HEADER;
            r_rem  <= '0;
            r_meth <= '0;
            r_sub  <= '0;
            r_skip <= 1'b0;
        end else begin
            r_mode <= n_mode;
            r_rem  <= n_rem;
            r_meth <= n_meth;
            r_sub  <= n_sub;
            r_skip <= n_skip;
        end
    end

    always_comb begin
        n_mode      = r_mode;
        n_rem       = r_rem;
        n_meth      = r_meth;
        n_sub       = r_sub;
        n_skip      = r_skip;
        o_cmd_valid = 1'b0;
        o_cmd       = '0;
        if (i_accept) begin
            n_skip = skip_now;
            if (r_mode != MODE_HEADER && r_rem != '0) begin
                // data word of a pending method (also resumes across entries)
                n_rem              = rem_dec;
                o_cmd_valid        = 1'b1;
                o_cmd.status       = STATUS_WRITE;
                o_cmd.method       = r_meth;
                o_cmd.argument     = i_word;
                o_cmd.subchannel   = r_sub;
                o_cmd.last         = (rem_dec == '0);
                unique case (r_mode)
                    MODE_INC: begin
                        n_meth = r_meth + METHOD_W'(1);
                    end
                    MODE_ONEINC: begin
                        n_meth = r_meth + METHOD_W'(1);
                        n_mode = MODE_NONINC;
                    end
                    default: ;
                endcase
                if (rem_dec == '0) begin
                    n_mode = MODE_HEADER;
                end
            end else begin
                n_mode = MODE_HEADER;
                n_rem  = '0;
                if (!skip_now && i_word != '0) begin
                    unique case (sec)
                        OP_INC, OP_NONINC, OP_ONEINC: begin
                            n_meth = METHOD_W'(hdr_addr);
                            n_sub  = hdr_sub;
                            n_rem  = hdr_cnt;
                            if (hdr_cnt != '0) begin
                                if (sec == OP_INC) begin
                                    n_mode = MODE_INC;
                                end else if (sec == OP_NONINC) begin
                                    n_mode = MODE_NONINC;
                                end else begin
                                    n_mode = MODE_ONEINC;
                                end
                            end
                        end
                        OP_IMMD: begin
                            n_meth           = METHOD_W'(hdr_addr);
                            n_sub            = hdr_sub;
                            o_cmd_valid      = 1'b1;
                            o_cmd.status     = STATUS_WRITE;
                            o_cmd.method     = METHOD_W'(hdr_addr);
                            o_cmd.argument   = WORD_W'(hdr_cnt);
                            o_cmd.subchannel = hdr_sub;
                            o_cmd.last       = 1'b1;
                        end
                        OP_END_SEG: begin
                            n_skip = 1'b1;
                        end
                        default: begin
                            // group 0 set-subdevice-mask is a no-op, all else errors
                            if (!(sec == OP_GRP0_USE_TERT && tert == TERT_SET_SUBDEV_MASK)) begin
                                n_skip           = 1'b1;
                                o_cmd_valid      = 1'b1;
                                o_cmd.status     = STATUS_ERROR;
                                o_cmd.method     = '0;
                                o_cmd.argument   = i_word;
                                o_cmd.subchannel = hdr_sub;
                                o_cmd.last       = 1'b1;
                            end
                        end
                    endcase
                end
            end
        end
    end

endmodule

// ===== sv/pmd_queue.sv =====
// ----------------------------------------------------------------------------
// pmd_queue
// Small command queue decoupling decode from issue.
// ----------------------------------------------------------------------------
module pmd_queue
    import pmd_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_cmd   i_cmd,
    input  logic   i_pop,
    output t_cmd   o_cmd,
    output t_qstat o_stat
);

    t_cmd              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr, n_wr;
    logic [QPTR_W-1:0] r_rd, n_rd;
    logic [QCNT_W-1:0] r_cnt, n_cnt;
    logic              do_push;
    logic              do_pop;

    assign o_stat.full  = (r_cnt == QCNT_W'(QDEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_cmd        = r_mem[r_rd];

    always_comb begin
        n_wr  = do_push ? r_wr + QPTR_W'(1) : r_wr;
        n_rd  = do_pop  ? r_rd + QPTR_W'(1) : r_rd;
        n_cnt = r_cnt + QCNT_W'(do_push) - QCNT_W'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

endmodule

// ===== sv/pmd_back.sv =====
// ----------------------------------------------------------------------------
// pmd_back
// Target classification against the limit registers and the result register.
// ----------------------------------------------------------------------------
module pmd_back
    import pmd_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic                i_cfg_index,
    input  logic [METHOD_W-1:0] i_cfg_data,
    input  t_cmd                i_cmd,
    input  t_qstat              i_qstat,
    output logic                o_qpop,
    input  logic                i_pop,
    output logic                o_valid,
    output logic                o_status,
    output logic [METHOD_W-1:0] o_method,
    output logic [WORD_W-1:0]   o_argument,
    output logic [SUBCH_W-1:0]  o_subchannel,
    output logic [CLASS_W-1:0]  o_target_class,
    output logic                o_last_of_method
);

    logic [HOST_W-1:0]   r_host_lim;
    logic [METHOD_W-1:0] r_eng_lim;
    logic                r_valid;
    t_cmd                r_cmd;
    logic [CLASS_W-1:0]  r_class;
    logic [CLASS_W-1:0]  cls;

    // Errors always report the host class
    always_comb begin
        priority if (i_cmd.status == STATUS_ERROR) begin
            cls = CLASS_HOST;
        end else if (i_cmd.method < METHOD_W'(r_host_lim)) begin
            cls = CLASS_HOST;
        end else if (i_cmd.method < r_eng_lim) begin
            cls = CLASS_ENGINE;
        end else begin
            cls = CLASS_MACRO;
        end
    end

    assign o_qpop = !i_qstat.empty && (!r_valid || i_pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_host_lim <= HOST_LIMIT_RST;
            r_eng_lim  <= ENGINE_LIMIT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_HOST_LIMIT:   r_host_lim <= i_cfg_data[HOST_W-1:0];
                CFG_ENGINE_LIMIT: r_eng_lim  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_qpop) begin
            r_valid <= 1'b1;
        end else if (i_pop) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_qpop) begin
            r_cmd   <= i_cmd;
            r_class <= cls;
        end
    end

    assign o_valid          = r_valid;
    assign o_status         = r_cmd.status;
    assign o_method         = r_cmd.method;
    assign o_argument       = r_cmd.argument;
    assign o_subchannel     = r_cmd.subchannel;
    assign o_target_class   = r_class;
    assign o_last_of_method = r_cmd.last;

endmodule

// ===== sv/pushbuffer_method_decoder.sv =====
// ----------------------------------------------------------------------------
// pushbuffer_method_decoder
// Decodes pushbuffer words into method writes, one word per cycle unless full.
// ----------------------------------------------------------------------------
//  channel   | handshake            | payload
//  ----------+----------------------+----------------------------------------
//  word in   | push / full          | i_word, i_entry_start
//  result    | empty / pop          | o_status, o_method, o_argument,
//            |                      | o_subchannel, o_target_class,
//            |                      | o_last_of_method
//  config    | i_cfg_we             | i_cfg_index, i_cfg_data
//
//  One word is taken per cycle while full is low. A word that yields a
//  result is written into the command queue when it is accepted; the issue
//  stage then classifies it into the result register once that register is
//  empty or being popped.
//  full rises when the 4-deep command queue is full; the result register
//  lets a result wait for pop while decode keeps filling the queue.
//  Synchronous active-low reset empties both stages and restores the limits.
// ----------------------------------------------------------------------------
module pushbuffer_method_decoder
    import pmd_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    // word input
    input  logic                push,
    output logic                full,
    input  logic [WORD_W-1:0]   i_word,
    input  logic                i_entry_start,
    // result output
    output logic                empty,
    input  logic                pop,
    output logic                o_status,
    output logic [METHOD_W-1:0] o_method,
    output logic [WORD_W-1:0]   o_argument,
    output logic [SUBCH_W-1:0]  o_subchannel,
    output logic [CLASS_W-1:0]  o_target_class,
    output logic                o_last_of_method,
    // configuration
    input  logic                i_cfg_we,
    input  logic                i_cfg_index,
    input  logic [METHOD_W-1:0] i_cfg_data
);

    logic   accept;
    logic   cmd_valid;
    t_cmd   cmd_in;
    t_cmd   cmd_out;
    t_qstat qstat;
    logic   qpop;
    logic   res_valid;

    // Full is taken from the queue alone, so a word that yields nothing
    // also waits while the queue is full.
    assign full   = qstat.full;
    assign accept = push && !full;
    assign empty  = !res_valid;

    // Decode: header parsing and per-word method sequencing
    pmd_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_word        (i_word),
        .i_entry_start (i_entry_start),
        .o_cmd_valid   (cmd_valid),
        .o_cmd         (cmd_in)
    );

    // Queue between decode and issue
    pmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_valid),
        .i_cmd   (cmd_in),
        .i_pop   (qpop),
        .o_cmd   (cmd_out),
        .o_stat  (qstat)
    );

    // Issue: classify against limits and hold the result for pop
    pmd_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_cmd            (cmd_out),
        .i_qstat          (qstat),
        .o_qpop           (qpop),
        .i_pop            (pop),
        .o_valid          (res_valid),
        .o_status         (o_status),
        .o_method         (o_method),
        .o_argument       (o_argument),
        .o_subchannel     (o_subchannel),
        .o_target_class   (o_target_class),
        .o_last_of_method (o_last_of_method)
    );

endmodule

// ===== sv/pmd_checker.sv =====
// ----------------------------------------------------------------------------
// pmd_checker
// Port-level checks of the method decoder, bound to the top level.
// ----------------------------------------------------------------------------
module pmd_checker
    import pmd_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                empty,
    input logic                pop,
    input logic                o_status,
    input logic [METHOD_W-1:0] o_method,
    input logic [WORD_W-1:0]   o_argument,
    input logic [CLASS_W-1:0]  o_target_class,
    input logic                o_last_of_method
);

    // nothing to show right after reset
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result shown after reset");

    // error words carry method 0, host class and the last flag
    a_error_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_status == STATUS_ERROR) |->
        (o_method == '0 && o_target_class == CLASS_HOST && o_last_of_method))
        else $error("malformed error word");

    // class code 3 is never produced
    a_class_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_target_class != 2'd3))
        else $error("bad target class");

    // a waiting result holds until popped
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_argument) && $stable(o_method)))
        else $error("waiting result changed");

endmodule

bind pushbuffer_method_decoder pmd_checker u_pmd_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .empty            (empty),
    .pop              (pop),
    .o_status         (o_status),
    .o_method         (o_method),
    .o_argument       (o_argument),
    .o_target_class   (o_target_class),
    .o_last_of_method (o_last_of_method)
);
